// ===== hdl/bdsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bdsc_pkg;

	localparam int NUM_DRIVES = 4;
	localparam int HARD_FIRST = 2;

	localparam int CYL_W  = 10;
	localparam int SECT_W = 6;
	localparam int HEAD_W = 8;
	localparam int MID_W  = 18;
	localparam int LBA_W  = 24;

	localparam int IN_DATA_W  = 80;
	localparam int IN_USER_W  = 8;
	localparam int OUT_DATA_W = 120;
	localparam int OUT_USER_W = 2;

	localparam int ADDR_W = 5;
	localparam int APB_W  = 32;

	// function codes (AH)
	localparam logic [7:0] FN_RESET      = 8'h00;
	localparam logic [7:0] FN_STATUS     = 8'h01;
	localparam logic [7:0] FN_READ       = 8'h02;
	localparam logic [7:0] FN_WRITE      = 8'h03;
	localparam logic [7:0] FN_FORMAT     = 8'h04;
	localparam logic [7:0] FN_FORMAT_ALT = 8'h05;
	localparam logic [7:0] FN_PARAMS     = 8'h08;

	// returned status codes
	localparam logic [7:0] ST_OK        = 8'h00;
	localparam logic [7:0] ST_BAD_CMD   = 8'h01;
	localparam logic [7:0] ST_NOT_READY = 8'hAA;

	localparam logic [7:0] HARD_BIAS = 8'd126;
	localparam logic [7:0] FLOPPY_BL = 8'd4;
	localparam logic [7:0] FLOPPY_DL = 8'd2;

	localparam logic [1:0] XFER_NONE  = 2'd0;
	localparam logic [1:0] XFER_READ  = 2'd1;
	localparam logic [1:0] XFER_WRITE = 2'd2;

	// register indexes
	localparam logic [2:0] REG_DRIVE_PRESENT = 3'd0;
	localparam logic [2:0] REG_FLOPPY_CYLS   = 3'd1;
	localparam logic [2:0] REG_FLOPPY_SECTS  = 3'd2;
	localparam logic [2:0] REG_FLOPPY_HEADS  = 3'd3;
	localparam logic [2:0] REG_HARD_CYLS     = 3'd4;
	localparam logic [2:0] REG_HARD_SECTS    = 3'd5;
	localparam logic [2:0] REG_HARD_HEADS    = 3'd6;
	localparam logic [2:0] REG_HARD_COUNT    = 3'd7;

	localparam logic [CYL_W-1:0]  RST_FLOPPY_CYLS  = 10'd80;
	localparam logic [SECT_W-1:0] RST_FLOPPY_SECTS = 6'd18;
	localparam logic [HEAD_W-1:0] RST_FLOPPY_HEADS = 8'd2;
	localparam logic [CYL_W-1:0]  RST_HARD_CYLS    = 10'd1023;
	localparam logic [SECT_W-1:0] RST_HARD_SECTS   = 6'd63;
	localparam logic [HEAD_W-1:0] RST_HARD_HEADS   = 8'd16;
	localparam logic [7:0]        RST_HARD_COUNT   = 8'd1;

	typedef struct packed {
		logic [CYL_W-1:0]  floppy_cylinders;
		logic [SECT_W-1:0] floppy_sectors;
		logic [HEAD_W-1:0] floppy_heads;
		logic [CYL_W-1:0]  hard_cylinders;
		logic [SECT_W-1:0] hard_sectors;
		logic [HEAD_W-1:0] hard_heads;
		logic [7:0]        hard_disk_count;
	} geom_cfg_t;

	typedef struct packed {
		logic capture;
		logic mul1;
		logic mul2;
		logic load;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hdl/bdsc_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdsc_regs #(
	parameter int NUM_DRIVES = bdsc_pkg::NUM_DRIVES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bdsc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [bdsc_pkg::APB_W-1:0]    pwdata,
	output logic      [bdsc_pkg::APB_W-1:0]    prdata,
	output logic                               pready,
	output logic      [NUM_DRIVES-1:0]         drive_present,
	output bdsc_pkg::geom_cfg_t                cfg
);

	logic [NUM_DRIVES-1:0] drive_present_q;
	bdsc_pkg::geom_cfg_t   cfg_q;
	logic [2:0]            idx;

	assign idx           = paddr[bdsc_pkg::ADDR_W-1:2];
	assign pready        = 1'b1;
	assign drive_present = drive_present_q;
	assign cfg           = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_present_q      <= '0;
			cfg_q.floppy_cylinders <= bdsc_pkg::RST_FLOPPY_CYLS;
			cfg_q.floppy_sectors   <= bdsc_pkg::RST_FLOPPY_SECTS;
			cfg_q.floppy_heads     <= bdsc_pkg::RST_FLOPPY_HEADS;
			cfg_q.hard_cylinders   <= bdsc_pkg::RST_HARD_CYLS;
			cfg_q.hard_sectors     <= bdsc_pkg::RST_HARD_SECTS;
			cfg_q.hard_heads       <= bdsc_pkg::RST_HARD_HEADS;
			cfg_q.hard_disk_count  <= bdsc_pkg::RST_HARD_COUNT;
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				bdsc_pkg::REG_DRIVE_PRESENT: drive_present_q <= pwdata[NUM_DRIVES-1:0];
				bdsc_pkg::REG_FLOPPY_CYLS: cfg_q.floppy_cylinders <= pwdata[bdsc_pkg::CYL_W-1:0];
				bdsc_pkg::REG_FLOPPY_SECTS: cfg_q.floppy_sectors <= pwdata[bdsc_pkg::SECT_W-1:0];
				bdsc_pkg::REG_FLOPPY_HEADS: cfg_q.floppy_heads <= pwdata[bdsc_pkg::HEAD_W-1:0];
				bdsc_pkg::REG_HARD_CYLS: cfg_q.hard_cylinders <= pwdata[bdsc_pkg::CYL_W-1:0];
				bdsc_pkg::REG_HARD_SECTS: cfg_q.hard_sectors <= pwdata[bdsc_pkg::SECT_W-1:0];
				bdsc_pkg::REG_HARD_HEADS: cfg_q.hard_heads <= pwdata[bdsc_pkg::HEAD_W-1:0];
				bdsc_pkg::REG_HARD_COUNT: cfg_q.hard_disk_count <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			bdsc_pkg::REG_DRIVE_PRESENT: prdata = bdsc_pkg::APB_W'(drive_present_q);
			bdsc_pkg::REG_FLOPPY_CYLS: prdata = bdsc_pkg::APB_W'(cfg_q.floppy_cylinders);
			bdsc_pkg::REG_FLOPPY_SECTS: prdata = bdsc_pkg::APB_W'(cfg_q.floppy_sectors);
			bdsc_pkg::REG_FLOPPY_HEADS: prdata = bdsc_pkg::APB_W'(cfg_q.floppy_heads);
			bdsc_pkg::REG_HARD_CYLS: prdata = bdsc_pkg::APB_W'(cfg_q.hard_cylinders);
			bdsc_pkg::REG_HARD_SECTS: prdata = bdsc_pkg::APB_W'(cfg_q.hard_sectors);
			bdsc_pkg::REG_HARD_HEADS: prdata = bdsc_pkg::APB_W'(cfg_q.hard_heads);
			bdsc_pkg::REG_HARD_COUNT: prdata = bdsc_pkg::APB_W'(cfg_q.hard_disk_count);
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/bdsc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdsc_dp #(
	parameter int NUM_DRIVES = bdsc_pkg::NUM_DRIVES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bdsc_pkg::cmd_t                    cmd,
	input  wire bdsc_pkg::geom_cfg_t               cfg,
	input  wire logic [NUM_DRIVES-1:0]             drive_present,
	input  wire logic [bdsc_pkg::IN_USER_W-1:0]    in_user,
	input  wire logic [bdsc_pkg::IN_DATA_W-1:0]    in_data,
	output logic      [bdsc_pkg::OUT_DATA_W-1:0]   out_data,
	output logic      [bdsc_pkg::OUT_USER_W-1:0]   out_user
);

	localparam int SW = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;

	logic [7:0]  mode_q, dl_q, ch_q, cl_q, dh_q, al_q, bl_q;
	logic [15:0] es_q, bx_q;

	logic [bdsc_pkg::MID_W-1:0] p1_q;
	logic [bdsc_pkg::LBA_W-1:0] lba_q;

	logic [7:0] last_status_q [NUM_DRIVES];
	logic       last_carry_q  [NUM_DRIVES];

	logic [7:0]                  slot8;
	logic                        valid;
	logic [SW-1:0]               sidx;
	logic                        present;
	logic                        hard;
	logic [bdsc_pkg::CYL_W-1:0]  cyls;
	logic [bdsc_pkg::SECT_W-1:0] sects;
	logic [bdsc_pkg::HEAD_W-1:0] heads;
	logic [bdsc_pkg::CYL_W-1:0]  cyl;
	logic [bdsc_pkg::SECT_W-1:0] sec;
	logic [bdsc_pkg::CYL_W-1:0]  maxc;

	logic [7:0]                 ah, ch_r, cl_r, dh_r, dl_r, bl_r;
	logic                       cf, store;
	logic [1:0]                 kind;
	logic [bdsc_pkg::LBA_W-1:0] lba_r;
	logic [15:0]                seg_r, off_r;

	assign slot8   = dl_q[7] ? (dl_q - bdsc_pkg::HARD_BIAS) : dl_q;
	assign valid   = slot8 < 8'(NUM_DRIVES);
	assign sidx    = slot8[SW-1:0];
	assign present = valid && drive_present[sidx];
	assign hard    = sidx >= SW'(bdsc_pkg::HARD_FIRST);
	assign cyls    = hard ? cfg.hard_cylinders : cfg.floppy_cylinders;
	assign sects   = hard ? cfg.hard_sectors : cfg.floppy_sectors;
	assign heads   = hard ? cfg.hard_heads : cfg.floppy_heads;
	assign cyl     = {cl_q[7:6], ch_q};
	assign sec     = cl_q[5:0];
	assign maxc    = cyls - 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_user;
			dl_q   <= in_data[7:0];
			ch_q   <= in_data[15:8];
			cl_q   <= in_data[23:16];
			dh_q   <= in_data[31:24];
			al_q   <= in_data[39:32];
			bl_q   <= in_data[47:40];
			es_q   <= in_data[63:48];
			bx_q   <= in_data[79:64];
		end
		if (cmd.mul1) begin
			p1_q <= bdsc_pkg::MID_W'(cyl) * bdsc_pkg::MID_W'(heads)
				+ bdsc_pkg::MID_W'(dh_q);
		end
		if (cmd.mul2) begin
			lba_q <= bdsc_pkg::LBA_W'(p1_q) * bdsc_pkg::LBA_W'(sects)
				+ bdsc_pkg::LBA_W'(sec) - bdsc_pkg::LBA_W'(1);
		end
	end

	always_comb begin
		ah    = mode_q;
		cf    = 1'b0;
		kind  = bdsc_pkg::XFER_NONE;
		lba_r = '0;
		seg_r = '0;
		off_r = '0;
		ch_r  = ch_q;
		cl_r  = cl_q;
		dh_r  = dh_q;
		dl_r  = dl_q;
		bl_r  = bl_q;
		store = 1'b1;
		case (mode_q) inside
			bdsc_pkg::FN_RESET, bdsc_pkg::FN_FORMAT, bdsc_pkg::FN_FORMAT_ALT: begin
				ah = bdsc_pkg::ST_OK;
			end
			bdsc_pkg::FN_STATUS: begin
				store = 1'b0;
				if (valid) begin
					ah = last_status_q[sidx];
					cf = last_carry_q[sidx];
				end else begin
					ah = bdsc_pkg::ST_OK;
				end
			end
			bdsc_pkg::FN_READ, bdsc_pkg::FN_WRITE: begin
				if (present) begin
					ah = bdsc_pkg::ST_OK;
					// sector zero: success without a transfer
					if (sec != '0) begin
						lba_r = lba_q;
						kind  = (mode_q == bdsc_pkg::FN_READ) ? bdsc_pkg::XFER_READ
							: bdsc_pkg::XFER_WRITE;
						seg_r = es_q;
						off_r = bx_q;
					end
				end else begin
					ah = bdsc_pkg::ST_BAD_CMD;
					cf = 1'b1;
				end
			end
			bdsc_pkg::FN_PARAMS: begin
				if (present) begin
					ah   = bdsc_pkg::ST_OK;
					ch_r = maxc[7:0];
					cl_r = {maxc[9:8], sects};
					dh_r = heads - 1'b1;
					if (!hard) begin
						bl_r = bdsc_pkg::FLOPPY_BL;
						dl_r = bdsc_pkg::FLOPPY_DL;
					end else begin
						dl_r = cfg.hard_disk_count;
					end
				end else begin
					ah = bdsc_pkg::ST_NOT_READY;
					cf = 1'b1;
				end
			end
			default: cf = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DRIVES; i++) begin
				last_status_q[i] <= '0;
				last_carry_q[i]  <= 1'b0;
			end
		end else if (cmd.load && store && valid) begin
			last_status_q[sidx] <= ah;
			last_carry_q[sidx]  <= cf;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_data <= {7'd0, off_r, seg_r, lba_r, bl_r, dl_r, dh_r, cl_r, ch_r, al_q, cf, ah};
			out_user <= kind;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bdsc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdsc_ctrl (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	output bdsc_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;

	assign s_tready    = (state_q == ST_IDLE);
	assign m_tvalid    = m_tvalid_q;
	assign cmd.capture = s_tvalid && s_tready;
	assign cmd.mul1    = (state_q == ST_MUL1);
	assign cmd.mul2    = (state_q == ST_MUL2);
	assign cmd.load    = (state_q == ST_LOAD) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_LOAD;
				ST_LOAD: begin
					if (cmd.load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	a_cap_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_MUL1))
		else $error("accepted call did not start the multiply sequence");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (m_tvalid_q && state_q == ST_IDLE))
		else $error("loaded result not presented");

	a_stall_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && m_tvalid_q && !m_tready) |=> (state_q == ST_LOAD))
		else $error("result overwritten while output stalled");

endmodule

`default_nettype wire

// ===== hdl/bios_disk_service_chs.sv =====
`timescale 1ns / 1ps
`default_nettype none

// BIOS disk service (INT 13h subset: reset, last status, read, write, format,
// get parameters). Each call is taken on the s_ stream and answered by one
// transfer on the m_ stream carrying the returned registers and, for read and
// write, a transfer command (kind, first LBA, buffer segment and offset; the
// consumer advances the offset by 512 per sector). When the returned DL has
// bit 7 set the consumer posts AH to 0x474. A call passes through capture,
// cylinder*heads+head, times sectors plus sector-1, then result load, which
// waits while an earlier result is still stalled; a new call is taken only
// after that load. Geometry and media presence are set through the APB
// registers, which the user must write only while no call is in progress;
// the block itself does not enforce this.

module bios_disk_service_chs #(
	parameter int NUM_DRIVES = bdsc_pkg::NUM_DRIVES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// drive_code, cyl_low, sector_cyl_high, head_in, count_in, bl_in,
	// es_segment, bx_offset
	input  wire logic [bdsc_pkg::IN_DATA_W-1:0]    s_tdata,
	// mode
	input  wire logic [bdsc_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// status_out, carry_out, count_out, cyl_low_out, sector_cyl_out, head_out,
	// drive_out, bl_out, lba_out, xfer_segment, xfer_offset, zero pad
	output logic      [bdsc_pkg::OUT_DATA_W-1:0]   m_tdata,
	// xfer_kind
	output logic      [bdsc_pkg::OUT_USER_W-1:0]   m_tuser,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [bdsc_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [bdsc_pkg::APB_W-1:0]        pwdata,
	output logic      [bdsc_pkg::APB_W-1:0]        prdata,
	output logic                                   pready
);

	bdsc_pkg::cmd_t        cmd;
	bdsc_pkg::geom_cfg_t   cfg;
	logic [NUM_DRIVES-1:0] drive_present;

	bdsc_regs #(
		.NUM_DRIVES(NUM_DRIVES)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.drive_present(drive_present),
		.cfg          (cfg)
	);

	bdsc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd)
	);

	bdsc_dp #(
		.NUM_DRIVES(NUM_DRIVES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.drive_present(drive_present),
		.in_user      (s_tuser),
		.in_data      (s_tdata),
		.out_data     (m_tdata),
		.out_user     (m_tuser)
	);

endmodule

`default_nettype wire
